// File: hw/rtl/lru_key_value_cache_macros.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared checks for the cache top level
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LKV_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// types and constants shared by the lru key-value cache modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

  // default sizing
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // fixed field widths
  localparam int WORD_BITS = 32;
  localparam int CAP_BITS  = 5;

  localparam logic [CAP_BITS-1:0]  CAP_RESET  = 5'd16;
  localparam logic [WORD_BITS-1:0] MISS_VALUE = '1;
  localparam logic [WORD_BITS-1:0] PUT_VALUE  = '0;

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic lookup;  // latch the key compare result
    logic write;   // apply the recency shift this cycle
    logic hit;     // the key was found somewhere in the row
    logic evict;   // a missing put drops the oldest entry
  } lkv_ctrl_t;

endpackage

// File: hw/rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell
// one entry of the recency-ordered row; position in the row is the recency
// rank, so an update shifts entries one cell toward the old end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkv_cell #(
  parameter int KW = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lkv_pkg::lkv_ctrl_t             ctrl_i,
  input  logic [KW-1:0]                  lookup_key_i,
  // content of the younger neighbor
  input  logic [KW-1:0]                  prev_key_i,
  input  logic [lkv_pkg::WORD_BITS-1:0]  prev_value_i,
  input  logic                           prev_valid_i,
  // match chain
  input  logic                           seen_i,
  input  logic [lkv_pkg::WORD_BITS-1:0]  hit_value_i,
  output logic                           seen_o,
  output logic [lkv_pkg::WORD_BITS-1:0]  hit_value_o,
  // own content toward the older neighbor
  output logic [KW-1:0]                  key_o,
  output logic [lkv_pkg::WORD_BITS-1:0]  value_o,
  output logic                           valid_o,
  output logic                           match_o
);

  logic [KW-1:0]                 key_q;
  logic [lkv_pkg::WORD_BITS-1:0] value_q;
  logic                          valid_q, valid_d;
  logic                          match_q, match_d;
  logic                          shift;

  // take the neighbor's entry: on a hit every cell up to the matching one,
  // on a miss every occupied position, plus the first free one unless evicting
  always_comb begin
    if (ctrl_i.hit) begin
      shift = ctrl_i.write & ~seen_i;
    end else begin
      shift = ctrl_i.write & prev_valid_i & (valid_q | ~ctrl_i.evict);
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.lookup) begin
      match_d = valid_q && (key_q == lookup_key_i);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (shift) begin
      valid_d = prev_valid_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  // match chain toward the old end
  assign seen_o      = seen_i | match_q;
  assign hit_value_o = hit_value_i | (match_q ? value_q : '0);

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement,
// built as a row of cells kept in recency order (cell 0 most recent)
//
//   channel   dir  fields (low bit first)          transfer when
//   s_axis    in   tuser: action; tdata: key,value  tvalid & tready
//   m_axis    out  tuser: hit; tdata: read_value    tvalid & tready
//   cfg       in   cfg_wdata_i: capacity_in_use     cfg_we_i
//
// for each item the key compare in every cell is registered at the input
// transfer, then the shift of the row happens in the update state.
// the update waits while the output register holds an untaken result; the
// next input transfer is taken once the update is done.
// reset clears all valid marks and the occupancy; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0]        cfg_wdata_i,   // capacity_in_use
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*lkv_pkg::WORD_BITS-1:0]     s_axis_tdata,  // key, value
  input  logic                                s_axis_tuser,  // action
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lkv_pkg::WORD_BITS-1:0]       m_axis_tdata,  // read_value
  output logic                                m_axis_tuser   // hit
);

  localparam int WB   = lkv_pkg::WORD_BITS;
  localparam int KW   = (KEY_BITS < WB) ? KEY_BITS : WB;
  localparam int OccW = $clog2(ENTRIES + 1);
  localparam int CmpW = (OccW > lkv_pkg::CAP_BITS) ? OccW : lkv_pkg::CAP_BITS;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [lkv_pkg::CAP_BITS-1:0] cap_q;
  logic [OccW-1:0]              occ_q, occ_d;
  logic                         action_q;
  logic [KW-1:0]                key_q;
  logic [WB-1:0]                value_q;

  logic                         out_valid_q, out_valid_d;
  logic                         out_hit_q;
  logic [WB-1:0]                out_data_q;

  logic                         in_xfer, update_fire, hit_any, evict;
  logic [CmpW-1:0]              cap_ext, occ_ext, ent_ext;
  logic [WB-1:0]                hit_value, front_value, result_value;
  lkv_pkg::lkv_ctrl_t           ctrl;

  logic [KW-1:0]                cell_key   [ENTRIES];
  logic [WB-1:0]                cell_value [ENTRIES];
  logic [ENTRIES-1:0]           cell_valid;
  logic [ENTRIES-1:0]           cell_match;
  logic [ENTRIES:0]             seen_chain;
  logic [WB-1:0]                hv_chain   [ENTRIES+1];
  logic [OccW-1:0]              valid_count;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign update_fire   = (state_q == ST_UPDATE) & (~out_valid_q | m_axis_tready);

  assign hit_any   = seen_chain[ENTRIES];
  assign hit_value = hv_chain[ENTRIES];

  // eviction test against the clamped capacity
  assign cap_ext = CmpW'(cap_q);
  assign occ_ext = CmpW'(occ_q);
  assign ent_ext = CmpW'(ENTRIES);
  always_comb begin
    if (cap_ext == '0) begin
      evict = (occ_ext >= CmpW'(1));
    end else if (cap_ext > ent_ext) begin
      evict = (occ_ext >= ent_ext);
    end else begin
      evict = (occ_ext >= cap_ext);
    end
  end

  // row control
  assign ctrl.lookup = in_xfer;
  assign ctrl.write  = update_fire & (hit_any | (action_q == lkv_pkg::ACT_PUT));
  assign ctrl.hit    = hit_any;
  assign ctrl.evict  = evict;

  // entry entering at the young end
  assign front_value = (action_q == lkv_pkg::ACT_PUT) ? value_q : hit_value;

  assign seen_chain[0] = 1'b0;
  assign hv_chain[0]   = '0;

  // row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KW-1:0] prev_key;
    logic [WB-1:0] prev_value;
    logic          prev_valid;

    if (i == 0) begin : g_front
      assign prev_key   = key_q;
      assign prev_value = front_value;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    lkv_cell #(
      .KW (KW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .lookup_key_i (s_axis_tdata[KW-1:0]),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .seen_i       (seen_chain[i]),
      .hit_value_i  (hv_chain[i]),
      .seen_o       (seen_chain[i+1]),
      .hit_value_o  (hv_chain[i+1]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (update_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // occupancy grows only on a missing put without eviction
  always_comb begin
    occ_d = occ_q;
    if (ctrl.write && !hit_any && !evict) begin
      occ_d = occ_q + OccW'(1);
    end
  end

  // result selection
  always_comb begin
    if (action_q == lkv_pkg::ACT_PUT) begin
      result_value = lkv_pkg::PUT_VALUE;
    end else if (hit_any) begin
      result_value = hit_value;
    end else begin
      result_value = lkv_pkg::MISS_VALUE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (update_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= lkv_pkg::CAP_RESET;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= s_axis_tuser;
      key_q    <= s_axis_tdata[KW-1:0];
      value_q  <= s_axis_tdata[2*WB-1:WB];
    end
    if (update_fire) begin
      out_hit_q  <= hit_any;
      out_data_q <= result_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

  // occupied cells, for the checks
  assign valid_count = OccW'($countones(cell_valid));

  // checks
  `LKV_ASSERT_ALWAYS(a_valid_count, clk_i, rst_ni, (valid_count == occ_q), "valid count off")
  `LKV_ASSERT_ALWAYS(a_unique_key, clk_i, rst_ni, ((state_q != ST_UPDATE) || $onehot0(cell_match)), "key stored in more than one cell")
  `LKV_ASSERT_NEXT(a_result_held, clk_i, rst_ni, update_fire, (m_axis_tvalid && (state_q == ST_IDLE)), "update did not post a result")

endmodule
